FILE: design/led_matrix_clock_renderer_unit_macros.svh
// Assertion helpers for the renderer unit.
`ifndef LED_MATRIX_CLOCK_RENDERER_UNIT_MACROS_SVH
`define LED_MATRIX_CLOCK_RENDERER_UNIT_MACROS_SVH

// Clocked check, held off while reset is asserted
`define LMCR_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default form for this block: clk_i / rst_ni
`define LMCR_ASSERT(label, prop, msg) \
  `LMCR_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: design/lmcr_pkg.sv
package lmcr_pkg;

  // Frame geometry
  localparam int unsigned ROW_COUNT        = 8;
  localparam int unsigned ROW_W            = 3;
  localparam int unsigned ROW_ADDR_W       = 4;
  localparam int unsigned MODULE_COUNT_DEF = 4;
  localparam int unsigned OUT_MODULES      = 4;
  localparam int unsigned GLYPH_SLOTS      = 5;

  // Input ranges
  localparam logic [6:0] CLOCK_MAX   = 7'd99;
  localparam logic [6:0] PERCENT_MAX = 7'd100;

  // Mode codes
  localparam logic [1:0] MODE_TIME    = 2'd0;
  localparam logic [1:0] MODE_PERCENT = 2'd1;

  // Glyph codes
  localparam int unsigned GLYPH_COUNT = 12;
  typedef logic [3:0] glyph_t;
  localparam glyph_t GLYPH_ZERO    = 4'd0;
  localparam glyph_t GLYPH_ONE     = 4'd1;
  localparam glyph_t GLYPH_COLON   = 4'd10;
  localparam glyph_t GLYPH_PERCENT = 4'd11;

  // 4x8 font, row i is nibble i, column j is bit 3-j of the nibble
  localparam logic [31:0] FONT [GLYPH_COUNT] = '{
    32'h06999996, 32'h04C4444E, 32'h0691248F, 32'h06912196,
    32'h0888AF22, 32'h0F8E1196, 32'h0698E996, 32'h0F122444,
    32'h06996996, 32'h06997196, 32'h00080800, 32'h0DD264BB
  };

  typedef enum logic [1:0] {
    LAY_BLANK,
    LAY_TIME,
    LAY_PCT,
    LAY_PCT_FULL
  } layout_e;

  // One rendered request: layout plus glyph per slot
  typedef struct packed {
    layout_e                         layout;
    logic [GLYPH_SLOTS-1:0][3:0]     glyph;
  } job_t;

  typedef struct packed {
    glyph_t tens;
    glyph_t ones;
  } digits_t;

  // Split a value 0..99 into decimal digits (reciprocal multiply by 205/2048)
  function automatic digits_t split_digits(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    digits_t     d;
    prod     = 15'(v) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    d.tens   = tens;
    d.ones   = 4'(v - tens_x10);
    return d;
  endfunction

  // Font row nibble of a glyph, blank for unused codes
  function automatic logic [3:0] font_row(input glyph_t g, input logic [ROW_W-1:0] r);
    logic [31:0] word;
    word = 32'h0;
    if (32'(g) < GLYPH_COUNT) word = FONT[g];
    return word[4*r +: 4];
  endfunction

  // Leftmost glyph column is the nibble MSB, so flip to column order
  function automatic logic [3:0] rev4(input logic [3:0] n);
    return {n[0], n[1], n[2], n[3]};
  endfunction

endpackage

FILE: design/lmcr_row_render.sv
module lmcr_row_render
  import lmcr_pkg::*;
#(
  parameter int unsigned MODULE_COUNT = MODULE_COUNT_DEF
) (
  input  job_t                           job_i,
  input  logic [ROW_W-1:0]               row_i,
  output logic [OUT_MODULES-1:0][7:0]    mod_bytes_o
);

  localparam int unsigned FRAME_COLS = 8 * MODULE_COUNT;

  // Glyph origins
  localparam int unsigned X_SLOT0  = 1;
  localparam int unsigned X_SLOT1  = 6;
  localparam int unsigned X_SLOT2  = 11;
  localparam int unsigned X_COLON  = 11;
  localparam int unsigned X_MIN_T  = 13;
  localparam int unsigned X_MIN_O  = 18;
  localparam int unsigned X_PCT_W  = 16;

  // Overwrite four columns at x with one glyph row (dark pixels too)
  function automatic logic [FRAME_COLS-1:0] put_glyph(
    input logic [FRAME_COLS-1:0] row,
    input int unsigned           x,
    input glyph_t                g,
    input logic [ROW_W-1:0]      r
  );
    logic [FRAME_COLS-1:0] mask;
    logic [FRAME_COLS-1:0] bits;
    mask = {{(FRAME_COLS-4){1'b0}}, 4'hF} << x;
    bits = {{(FRAME_COLS-4){1'b0}}, rev4(font_row(g, r))} << x;
    return (row & ~mask) | bits;
  endfunction

  logic [FRAME_COLS-1:0] row_bits;

  // Compose the selected row, later glyphs win
  always_comb begin
    row_bits = '0;
    unique case (job_i.layout)
      LAY_TIME: begin
        row_bits = put_glyph(row_bits, X_SLOT0, job_i.glyph[0], row_i);
        row_bits = put_glyph(row_bits, X_SLOT1, job_i.glyph[1], row_i);
        row_bits = put_glyph(row_bits, X_COLON, job_i.glyph[2], row_i);
        row_bits = put_glyph(row_bits, X_MIN_T, job_i.glyph[3], row_i);
        row_bits = put_glyph(row_bits, X_MIN_O, job_i.glyph[4], row_i);
      end
      LAY_PCT_FULL: begin
        row_bits = put_glyph(row_bits, X_SLOT0, job_i.glyph[0], row_i);
        row_bits = put_glyph(row_bits, X_SLOT1, job_i.glyph[1], row_i);
        row_bits = put_glyph(row_bits, X_SLOT2, job_i.glyph[2], row_i);
        row_bits = put_glyph(row_bits, X_PCT_W, job_i.glyph[3], row_i);
      end
      LAY_PCT: begin
        row_bits = put_glyph(row_bits, X_SLOT0, job_i.glyph[0], row_i);
        row_bits = put_glyph(row_bits, X_SLOT1, job_i.glyph[1], row_i);
        row_bits = put_glyph(row_bits, X_SLOT2, job_i.glyph[2], row_i);
      end
      LAY_BLANK: row_bits = '0;
      default:   row_bits = '0;
    endcase
  end

  // Slice into driver bytes; absent modules read as zero
  for (genvar gm = 0; gm < OUT_MODULES; gm++) begin : g_mod
    if (gm < MODULE_COUNT) begin : g_present
      assign mod_bytes_o[gm] = row_bits[gm*8 +: 8];
    end else begin : g_absent
      assign mod_bytes_o[gm] = 8'h00;
    end
  end

endmodule

FILE: design/led_matrix_clock_renderer_unit.sv
// LED matrix clock renderer.
// Input channel (in_valid_i / in_stall_o): one refresh request carries mode,
// hours, minutes and brightness. Output channel (out_valid_o / out_stall_i):
// eight row frames per request, row_address 1..8 in order, with the driver
// bytes for modules 3..0 and last_row set on the eighth frame.
// Path: a taken request is registered, then each row is composed from it and
// held in the output register; rows follow in order while the receiver takes.
// Rate: one row per cycle from the single row renderer while the output is
// not stalled; the next request is taken in the cycle the eighth row is
// rendered, so frames stream without gaps.
// Stall: a stalled output frame holds; rendering pauses and in_stall_o stays
// high until the last row of the current request moves to the output.
// Reset: asynchronous, clears the request and output valid flags; no frame
// is pending after reset.
`include "led_matrix_clock_renderer_unit_macros.svh"

module led_matrix_clock_renderer_unit
  import lmcr_pkg::*;
#(
  parameter int unsigned MODULE_COUNT = MODULE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            mode_i,
  input  logic [6:0]            hours_i,
  input  logic [6:0]            minutes_i,
  input  logic [6:0]            brightness_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ROW_ADDR_W-1:0] row_address_o,
  output logic [7:0]            module3_byte_o,
  output logic [7:0]            module2_byte_o,
  output logic [7:0]            module1_byte_o,
  output logic [7:0]            module0_byte_o,
  output logic                  last_row_o
);

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);

  logic                           job_valid_q, job_valid_d;
  job_t                           job_q, job_d;
  logic [ROW_W-1:0]               row_q, row_d;
  logic                           out_valid_q, out_valid_d;
  logic [ROW_ADDR_W-1:0]          addr_q;
  logic [OUT_MODULES-1:0][7:0]    bytes_q;
  logic                           last_q;
  logic [OUT_MODULES-1:0][7:0]    row_bytes;

  logic    out_free, advance, job_done, in_take;
  logic [6:0] hr_sat, mn_sat, br_sat;
  digits_t hr_dig, mn_dig, br_dig;

  // Handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = job_valid_q && out_free;
  assign job_done   = advance && (row_q == LAST_ROW);
  assign in_stall_o = job_valid_q && !job_done;
  assign in_take    = in_valid_i && !in_stall_o;

  // Request decode: saturate, split digits, pick layout
  assign hr_sat = (hours_i > CLOCK_MAX)        ? CLOCK_MAX   : hours_i;
  assign mn_sat = (minutes_i > CLOCK_MAX)      ? CLOCK_MAX   : minutes_i;
  assign br_sat = (brightness_i > PERCENT_MAX) ? PERCENT_MAX : brightness_i;
  assign hr_dig = split_digits(hr_sat);
  assign mn_dig = split_digits(mn_sat);
  assign br_dig = split_digits(br_sat);

  always_comb begin
    job_d        = '0;
    job_d.layout = LAY_BLANK;
    priority if (mode_i == MODE_TIME) begin
      job_d.layout   = LAY_TIME;
      job_d.glyph[0] = hr_dig.tens;
      job_d.glyph[1] = hr_dig.ones;
      job_d.glyph[2] = GLYPH_COLON;
      job_d.glyph[3] = mn_dig.tens;
      job_d.glyph[4] = mn_dig.ones;
    end else if (mode_i == MODE_PERCENT && br_sat == PERCENT_MAX) begin
      job_d.layout   = LAY_PCT_FULL;
      job_d.glyph[0] = GLYPH_ONE;
      job_d.glyph[1] = GLYPH_ZERO;
      job_d.glyph[2] = GLYPH_ZERO;
      job_d.glyph[3] = GLYPH_PERCENT;
    end else if (mode_i == MODE_PERCENT) begin
      job_d.layout   = LAY_PCT;
      job_d.glyph[0] = br_dig.tens;
      job_d.glyph[1] = br_dig.ones;
      job_d.glyph[2] = GLYPH_PERCENT;
    end else begin
      job_d.layout = LAY_BLANK;
    end
  end

  // Request register and row counter
  always_comb begin
    job_valid_d = job_valid_q;
    row_d       = row_q;
    if (in_take) begin
      job_valid_d = 1'b1;
      row_d       = '0;
    end else if (advance) begin
      job_valid_d = !job_done;
      row_d       = row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      row_q       <= '0;
    end else begin
      job_valid_q <= job_valid_d;
      row_q       <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      job_q <= job_d;
    end
  end

  // Row composition
  lmcr_row_render #(
    .MODULE_COUNT(MODULE_COUNT)
  ) u_row_render (
    .job_i      (job_q),
    .row_i      (row_q),
    .mod_bytes_o(row_bytes)
  );

  // Output register
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      addr_q  <= ROW_ADDR_W'(row_q) + ROW_ADDR_W'(1);
      bytes_q <= row_bytes;
      last_q  <= (row_q == LAST_ROW);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_address_o  = addr_q;
  assign module3_byte_o = bytes_q[3];
  assign module2_byte_o = bytes_q[2];
  assign module1_byte_o = bytes_q[1];
  assign module0_byte_o = bytes_q[0];
  assign last_row_o     = last_q;

  // Checks
  `LMCR_ASSERT(a_row_seq,
    out_valid_o && !out_stall_i && !last_row_o |=>
      out_valid_o && (row_address_o == $past(row_address_o) + ROW_ADDR_W'(1)),
    "row frames of a request are not contiguous")
  `LMCR_ASSERT(a_last_flag,
    out_valid_o |-> (last_row_o == (row_address_o == ROW_ADDR_W'(ROW_COUNT))),
    "last_row does not match the eighth row address")
  `LMCR_ASSERT(a_no_overrun,
    job_valid_q && (row_q != LAST_ROW) |-> in_stall_o,
    "request accepted while rows are still pending")

endmodule

FILE: dv/tb_led_matrix_clock_renderer_unit.sv
`timescale 1ns / 1ps

module tb_led_matrix_clock_renderer_unit;
  import lmcr_pkg::*;

  // Blank display modes, outside the package's named codes
  localparam logic [1:0] MODE_BLANK_A = 2'd2;
  localparam logic [1:0] MODE_BLANK_B = 2'd3;

  localparam int unsigned MODULES        = MODULE_COUNT_DEF;
  localparam int unsigned FRAME_W        = 8 * MODULES;
  localparam int unsigned RANDOM_ITEMS   = 310;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 10;

  // 4x8 font: digits 0-9, colon, percent; row i is nibble i
  localparam logic [31:0] DIGIT_FONT [12] = '{
    32'h06999996, 32'h04C4444E, 32'h0691248F, 32'h06912196,
    32'h0888AF22, 32'h0F8E1196, 32'h0698E996, 32'h0F122444,
    32'h06996996, 32'h06997196, 32'h00080800, 32'h0DD264BB
  };

  typedef struct {
    logic [1:0] mode;
    logic [6:0] hours;
    logic [6:0] minutes;
    logic [6:0] brightness;
    bit         drain_first;
  } refresh_req_t;

  typedef struct packed {
    logic [3:0] row_address;
    logic [7:0] module3;
    logic [7:0] module2;
    logic [7:0] module1;
    logic [7:0] module0;
    logic       last_row;
  } row_frame_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid     = 1'b0;
  logic [1:0] req_mode     = '0;
  logic [6:0] req_hours    = '0;
  logic [6:0] req_minutes  = '0;
  logic [6:0] req_bright   = '0;
  logic       out_stall    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [ROW_ADDR_W-1:0] row_address_o;
  logic [7:0] module3_byte_o;
  logic [7:0] module2_byte_o;
  logic [7:0] module1_byte_o;
  logic [7:0] module0_byte_o;
  logic       last_row_o;

  refresh_req_t pending_reqs [$];
  row_frame_t   expected_rows [$];
  logic [FRAME_W-1:0] frame_pix [ROW_COUNT];

  logic        in_taken       = 1'b0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned requests_taken = 0;
  int unsigned rows_seen      = 0;
  int unsigned idle_cycles    = 0;
  int unsigned mismatch_count = 0;

  led_matrix_clock_renderer_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .mode_i         (req_mode),
    .hours_i        (req_hours),
    .minutes_i      (req_minutes),
    .brightness_i   (req_bright),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .row_address_o  (row_address_o),
    .module3_byte_o (module3_byte_o),
    .module2_byte_o (module2_byte_o),
    .module1_byte_o (module1_byte_o),
    .module0_byte_o (module0_byte_o),
    .last_row_o     (last_row_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Glyph writes lit and dark pixels; columns past the frame are dropped
  function automatic void paint_glyph(input int unsigned col, input logic [3:0] g);
    logic [31:0] word;
    logic [3:0]  nib;
    int unsigned c;
    word = (g < 12) ? DIGIT_FONT[g] : 32'h0;
    for (int i = 0; i < ROW_COUNT; i++) begin
      nib = word[4*i +: 4];
      for (int j = 0; j < 4; j++) begin
        c = col + j;
        if (c < FRAME_W) frame_pix[i][c] = nib[3-j];
      end
    end
  endfunction

  // Render one refresh request and queue its eight row frames
  function automatic void render_refresh(input logic [1:0] mode, input logic [6:0] hours,
                                         input logic [6:0] minutes, input logic [6:0] bright);
    int unsigned hr;
    int unsigned mn;
    int unsigned br;
    row_frame_t  rf;
    hr = (hours > CLOCK_MAX) ? 99 : hours;
    mn = (minutes > CLOCK_MAX) ? 99 : minutes;
    br = (bright > PERCENT_MAX) ? 100 : bright;
    for (int i = 0; i < ROW_COUNT; i++) frame_pix[i] = '0;
    if (mode == MODE_TIME) begin
      paint_glyph(1, 4'(hr / 10));
      paint_glyph(6, 4'(hr % 10));
      paint_glyph(11, GLYPH_COLON);
      paint_glyph(13, 4'(mn / 10));
      paint_glyph(18, 4'(mn % 10));
    end else if (mode == MODE_PERCENT) begin
      if (br == 100) begin
        paint_glyph(1, GLYPH_ONE);
        paint_glyph(6, GLYPH_ZERO);
        paint_glyph(11, GLYPH_ZERO);
        paint_glyph(16, GLYPH_PERCENT);
      end else begin
        paint_glyph(1, 4'(br / 10));
        paint_glyph(6, 4'(br % 10));
        paint_glyph(11, GLYPH_PERCENT);
      end
    end
    for (int r = 0; r < ROW_COUNT; r++) begin
      rf.row_address = 4'(r + 1);
      rf.module3     = frame_pix[r][31:24];
      rf.module2     = frame_pix[r][23:16];
      rf.module1     = frame_pix[r][15:8];
      rf.module0     = frame_pix[r][7:0];
      rf.last_row    = (r == ROW_COUNT - 1);
      expected_rows.push_back(rf);
    end
  endfunction

  // Four-state compare so unknown outputs are flagged
  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  function automatic void add_request(input logic [1:0] mode, input logic [6:0] hours,
                                      input logic [6:0] minutes, input logic [6:0] bright,
                                      input bit drain_first);
    refresh_req_t req;
    req.mode        = mode;
    req.hours       = hours;
    req.minutes     = minutes;
    req.brightness  = bright;
    req.drain_first = drain_first;
    pending_reqs.push_back(req);
  endfunction

  // Clock value: mostly 0..99, sometimes above to hit saturation
  function automatic logic [6:0] rand_clock_value();
    return ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                       : 7'($urandom_range(0, 99));
  endfunction

  // Idle gap after an accepted request: mostly none, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (((requests_taken / 32) % 4) == 1) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // Request driver
  always @(negedge clk_i) begin : drive_requests
    refresh_req_t req;
    logic         nv;
    int unsigned  gl;
    if (rst_ni && (!in_valid || in_taken)) begin
      gl = gap_left;
      nv = 1'b0;
      if (in_valid) gl = pick_gap();
      if (gl != 0) begin
        gl--;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && expected_rows.size() != 0)) begin
        req = pending_reqs.pop_front();
        req_mode    <= req.mode;
        req_hours   <= req.hours;
        req_minutes <= req.minutes;
        req_bright  <= req.brightness;
        nv = 1'b1;
      end
      in_valid <= nv;
      gap_left <= gl;
    end
  end

  // Receiver back-pressure, with quiet stretches
  always @(negedge clk_i) begin : drive_stall
    int unsigned r;
    if (rst_ni) begin
      r = $urandom_range(0, 99);
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (((rows_seen / 64) % 4) == 2 || r < 65) begin
        out_stall <= 1'b0;
      end else if (r < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(5, 25);
      end
    end
  end

  // Check row frames, then predict for a newly accepted request
  always @(posedge clk_i) begin : monitor
    row_frame_t exp_row;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        rows_seen <= rows_seen + 1;
        if (expected_rows.size() == 0) begin
          $error("unexpected row frame, row_address %0d", row_address_o);
          mismatch_count++;
        end else begin
          exp_row = expected_rows.pop_front();
          check_field("row_address", 8'(exp_row.row_address), 8'(row_address_o));
          check_field("module3_byte", exp_row.module3, module3_byte_o);
          check_field("module2_byte", exp_row.module2, module2_byte_o);
          check_field("module1_byte", exp_row.module1, module1_byte_o);
          check_field("module0_byte", exp_row.module0, module0_byte_o);
          check_field("last_row", 8'(exp_row.last_row), 8'(last_row_o));
        end
      end
      if (in_valid && !in_stall_o) begin
        render_refresh(req_mode, req_hours, req_minutes, req_bright);
        requests_taken <= requests_taken + 1;
      end
      in_taken <= in_valid && !in_stall_o;
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_led_matrix_clock_renderer_unit: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [1:0] mode;
    int unsigned r;
    int unsigned b;

    // Directed: digit extremes, saturation, full percent, blank modes
    add_request(MODE_TIME, 7'd0, 7'd0, 7'd0, 1'b0);
    add_request(MODE_TIME, 7'd99, 7'd99, 7'd100, 1'b0);
    add_request(MODE_TIME, 7'd127, 7'd127, 7'd127, 1'b0);
    add_request(MODE_TIME, 7'd100, 7'd100, 7'd0, 1'b0);
    add_request(MODE_TIME, 7'd23, 7'd59, 7'd42, 1'b0);
    add_request(MODE_TIME, 7'd12, 7'd34, 7'd100, 1'b0);
    add_request(MODE_TIME, 7'd56, 7'd78, 7'd5, 1'b0);
    add_request(MODE_TIME, 7'd90, 7'd7, 7'd127, 1'b0);
    add_request(MODE_TIME, 7'd45, 7'd61, 7'd99, 1'b0);
    add_request(MODE_PERCENT, 7'd0, 7'd0, 7'd0, 1'b0);
    add_request(MODE_PERCENT, 7'd127, 7'd127, 7'd9, 1'b0);
    add_request(MODE_PERCENT, 7'd12, 7'd34, 7'd10, 1'b0);
    add_request(MODE_PERCENT, 7'd99, 7'd99, 7'd55, 1'b0);
    add_request(MODE_PERCENT, 7'd1, 7'd1, 7'd99, 1'b0);
    add_request(MODE_PERCENT, 7'd0, 7'd0, 7'd100, 1'b0);
    add_request(MODE_PERCENT, 7'd88, 7'd88, 7'd101, 1'b0);
    add_request(MODE_PERCENT, 7'd0, 7'd0, 7'd127, 1'b0);
    add_request(MODE_BLANK_A, 7'd88, 7'd88, 7'd88, 1'b0);
    add_request(MODE_BLANK_B, 7'd127, 7'd127, 7'd127, 1'b0);
    add_request(MODE_TIME, 7'd38, 7'd26, 7'd100, 1'b0);

    // Random: mostly time and percent, some blank; drain twice on the way
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) mode = MODE_TIME;
      else if (r < 85) mode = MODE_PERCENT;
      else mode = $urandom_range(0, 1) ? MODE_BLANK_A : MODE_BLANK_B;
      r = $urandom_range(0, 9);
      if (r == 0) b = $urandom_range(101, 127);
      else if (r == 1) b = 100;
      else b = $urandom_range(0, 99);
      add_request(mode, rand_clock_value(), rand_clock_value(), 7'(b),
                  (n == 0) || (n == RANDOM_ITEMS / 2));
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0 && !in_valid && expected_rows.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_led_matrix_clock_renderer_unit: PASS");
    end else begin
      $display("tb_led_matrix_clock_renderer_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lmcr_pkg.sv
design/lmcr_row_render.sv
design/led_matrix_clock_renderer_unit.sv
dv/tb_led_matrix_clock_renderer_unit.sv
